### rtl/mbps_pkg.sv
// Package for the masked byte pattern scanner: widths, register indexes,
// reset values and the per-cell compare setup. No dependencies.
package mbps_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int PAT_BYTES       = 16;
    localparam int LEN_W           = 5;
    localparam int CNT_W           = 32;
    localparam int ADDR_W          = 64;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_MASK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LAST    = 3'd5;

    localparam logic [PAT_BYTES-1:0] MASK_RESET = 16'hFFFF;
    localparam logic [LEN_W-1:0]     LEN_RESET  = 5'd1;

    // Compare setup handed to one cell of the window
    typedef struct packed {
        logic       care;
        logic [7:0] expected;
    } cell_cfg_t;

    // Setup for the cell holding the byte 'back' steps behind the newest one
    function automatic cell_cfg_t cell_setup(
        input logic [8*PAT_BYTES-1:0] pattern,
        input logic [PAT_BYTES-1:0]   mask,
        input logic [LEN_W-1:0]       len,
        input logic [LEN_W-1:0]       back
    );
        cell_cfg_t       c;
        logic [LEN_W-1:0] j;
        j          = len - back - LEN_W'(1);
        c.care     = (back < len) && mask[j[3:0]];
        c.expected = pattern[{j[3:0], 3'b000} +: 8];
        return c;
    endfunction

endpackage

### rtl/mbps_cell.sv
// One window cell of the masked byte pattern scanner: holds one byte,
// passes it on to the next cell and compares it. Depends on mbps_pkg.
module mbps_cell
    import mbps_pkg::*;
(
    input  logic      aclk,
    input  logic      shift_en,
    input  logic [7:0] byte_in,
    input  cell_cfg_t cfg,
    output logic [7:0] byte_out,
    output logic      hit
);

    logic [7:0] byte_reg;

    // window contents only count once a whole candidate lies in the range
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;
    assign hit      = !cfg.care || (byte_reg == cfg.expected);

endmodule

### rtl/masked_byte_pattern_scan.sv
// Masked byte pattern scanner, top level. Depends on mbps_pkg, mbps_cell.
// Throughput: one byte per cycle while the result stages are not stalled, set
//   by the window chain and its parallel compare; back-to-back ranges run with no gap.
// Result path: once the last byte is accepted, the result passes the result
//   hold stage, then the output register with the address add.
// Reset: aresetn synchronous, active low; registers take their reset values,
//   scan state clears, no result pending.
module masked_byte_pattern_scan
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // byte stream in
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic                  s_tlast,   // last_byte
    // result out
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [ADDR_W-1:0]     m_tdata,   // [63:0] match_address
    output logic                  m_tuser    // [0] found
);

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // ---------------- configuration registers ----------------
    logic [ADDR_W-1:0]      base_reg;
    logic [8*PAT_BYTES-1:0] pattern_reg;
    logic [PAT_BYTES-1:0]   mask_reg;
    logic [LEN_W-1:0]       len_reg;
    logic                   last_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg      <= '0;
            pattern_reg   <= '0;
            mask_reg      <= MASK_RESET;
            len_reg       <= LEN_RESET;
            last_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_BASE_ADDRESS:   base_reg                <= cfg_wdata;
                CFG_PATTERN_LOW:    pattern_reg[63:0]       <= cfg_wdata;
                CFG_PATTERN_HIGH:   pattern_reg[127:64]     <= cfg_wdata;
                CFG_COMPARE_MASK:   mask_reg                <= cfg_wdata[PAT_BYTES-1:0];
                CFG_PATTERN_LENGTH: len_reg                 <= cfg_wdata[LEN_W-1:0];
                CFG_SEARCH_LAST:    last_mode_reg           <= cfg_wdata[0];
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    // clamp the pattern length to what the window supports
    logic [LEN_W-1:0] len_eff;
    assign len_eff = (len_reg > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_reg;

    // ---------------- handshake ----------------
    logic accept;
    logic last_acc;
    logic b_load;
    logic a_valid_reg;

    assign b_load   = !m_tvalid || m_tready;
    assign s_tready = !a_valid_reg || b_load;
    assign accept   = s_tvalid && s_tready;
    assign last_acc = accept && s_tlast;

    // ---------------- window: chain of cells ----------------
    // Entry 0 is the arriving byte; entry b is the byte b steps back.
    logic [7:0]             win_byte [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] hit;
    cell_cfg_t              lane_cfg [MAX_PATTERN];

    assign win_byte[0] = s_tdata[7:0];

    genvar b;
    generate
        for (b = 0; b < MAX_PATTERN; b++) begin : g_lane
            assign lane_cfg[b] = cell_setup(pattern_reg, mask_reg, len_eff, LEN_W'(b));
        end
        for (b = 1; b < MAX_PATTERN; b++) begin : g_cell
            mbps_cell u_cell (
                .aclk     (aclk),
                .shift_en (accept),
                .byte_in  (win_byte[b-1]),
                .cfg      (lane_cfg[b]),
                .byte_out (win_byte[b]),
                .hit      (hit[b])
            );
        end
    endgenerate

    // the arriving byte is compared in place, ahead of the first cell
    assign hit[0] = !lane_cfg[0].care || (win_byte[0] == lane_cfg[0].expected);

    // ---------------- match tracking ----------------
    logic [CNT_W-1:0] count_reg, count_next;
    logic             seen_reg, seen_next;
    logic [CNT_W-1:0] offset_reg, offset_next;
    logic [CNT_W-1:0] count_inc;
    logic             cand_hit;

    assign count_inc = count_reg + CNT_W'(1);
    assign cand_hit  = (count_reg != COUNT_MAX) && (len_eff != '0)
                    && (count_inc >= CNT_W'(len_eff)) && (&hit);

    always_comb begin
        count_next  = count_reg;
        seen_next   = seen_reg;
        offset_next = offset_reg;
        if (count_reg != COUNT_MAX) begin
            count_next = count_inc;
        end
        // first mode keeps the lowest start, last mode the newest one
        if (cand_hit && (last_mode_reg || !seen_reg)) begin
            offset_next = count_inc - CNT_W'(len_eff);
            seen_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            seen_reg   <= 1'b0;
            offset_reg <= '0;
        end else if (last_acc) begin
            // range done: clear the scan for the next one
            count_reg  <= '0;
            seen_reg   <= 1'b0;
            offset_reg <= '0;
        end else if (accept) begin
            count_reg  <= count_next;
            seen_reg   <= seen_next;
            offset_reg <= offset_next;
        end
    end

    // ---------------- result hold stage ----------------
    logic             a_found_reg;
    logic [CNT_W-1:0] a_offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (last_acc) begin
            a_valid_reg <= 1'b1;
        end else if (b_load) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (last_acc) begin
            a_found_reg  <= seen_next;
            a_offset_reg <= offset_next;
        end
    end

    // ---------------- output register ----------------
    logic                m_valid_reg;
    logic                m_found_reg;
    logic [ADDR_W-1:0]   m_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (b_load) begin
            m_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_load && a_valid_reg) begin
            m_found_reg <= a_found_reg;
            m_addr_reg  <= a_found_reg ? (base_reg + ADDR_W'(a_offset_reg)) : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_addr_reg;
    assign m_tuser  = m_found_reg;

    // ---------------- assertions ----------------
    // a pending result must hold while the output stage is stalled
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && !b_load |=> a_valid_reg && $stable(a_offset_reg)
                                   && $stable(a_found_reg))
        else $error("pending result lost while output stalled");

    // the scan clears after the last byte of a range
    scan_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        last_acc |=> count_reg == '0 && !seen_reg)
        else $error("scan state not cleared after last byte");

    // no address reported without a match
    addr_zero_when_missing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_found_reg |-> m_addr_reg == '0)
        else $error("address given without a match");

    // the byte count holds once saturated, until the last byte of the range
    count_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == COUNT_MAX && accept && !s_tlast |=> count_reg == COUNT_MAX)
        else $error("byte count wrapped past saturation");

endmodule

### tb/sv/scan_checker.sv
`timescale 1ns / 100ps
// Result checker for the masked byte pattern scanner: follows register writes
// and accepted bytes, predicts each range result and compares. Uses mbps_pkg.
module scan_checker
    import mbps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [ADDR_W-1:0]     m_tdata,
    input  logic                  m_tuser,
    output int                    fail_count,
    output int                    pending_results
);

    localparam int               WIN_DEPTH  = MAX_PATTERN_DEF - 1;
    localparam logic [CNT_W-1:0] COUNT_CEIL = '1;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] addr;
    } scan_result_t;

    // register copies
    logic [ADDR_W-1:0]      base_q;
    logic [8*PAT_BYTES-1:0] pattern_q;
    logic [PAT_BYTES-1:0]   mask_q;
    logic [LEN_W-1:0]       len_q;
    logic                   last_mode_q;

    // scan state of the current range
    logic [7:0]       window_q [WIN_DEPTH];
    logic [CNT_W-1:0] taken_q;
    logic             seen_q;
    logic [CNT_W-1:0] offset_q;

    scan_result_t range_results [$];

    initial begin
        fail_count      = 0;
        pending_results = 0;
    end

    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                   input logic [ADDR_W-1:0] want);
        $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic clear_scan();
        int k;
        for (k = 0; k < WIN_DEPTH; k++) window_q[k] = 8'h00;
        taken_q  = '0;
        seen_q   = 1'b0;
        offset_q = '0;
    endtask

    always @(posedge aclk) begin : track
        int           len;
        int           j;
        int           k;
        bit           hit;
        logic [7:0]   b;
        scan_result_t want;
        if (!aresetn) begin
            base_q      = '0;
            pattern_q   = '0;
            mask_q      = MASK_RESET;
            len_q       = LEN_RESET;
            last_mode_q = 1'b0;
            clear_scan();
            range_results.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_BASE_ADDRESS:   base_q           = cfg_wdata;
                    CFG_PATTERN_LOW:    pattern_q[63:0]   = cfg_wdata;
                    CFG_PATTERN_HIGH:   pattern_q[127:64] = cfg_wdata;
                    CFG_COMPARE_MASK:   mask_q           = cfg_wdata[PAT_BYTES-1:0];
                    CFG_PATTERN_LENGTH: len_q            = cfg_wdata[LEN_W-1:0];
                    CFG_SEARCH_LAST:    last_mode_q      = cfg_wdata[0];
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready) begin
                if (range_results.size() == 0) begin
                    report_mismatch("result item with none expected", m_tdata, '0);
                end else begin
                    want = range_results.pop_front();
                    if (m_tuser !== want.found)
                        report_mismatch("found", ADDR_W'(m_tuser), ADDR_W'(want.found));
                    if (m_tdata !== want.addr)
                        report_mismatch("match_address", m_tdata, want.addr);
                end
            end

            if (s_tvalid && s_tready) begin
                len = (len_q > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(len_q);
                // a saturated count still shifts the window but starts nothing new
                if (taken_q != COUNT_CEIL) begin
                    taken_q = taken_q + 1'b1;
                    if (len != 0 && taken_q >= CNT_W'(len)) begin
                        hit = 1'b1;
                        for (j = 0; j < len; j++) begin
                            if (mask_q[j]) begin
                                if (j == len - 1) b = s_tdata;
                                else b = window_q[len - 2 - j];
                                if (b !== pattern_q[8*j +: 8]) hit = 1'b0;
                            end
                        end
                        if (hit && (last_mode_q || !seen_q)) begin
                            offset_q = taken_q - CNT_W'(len);
                            seen_q   = 1'b1;
                        end
                    end
                end
                for (k = WIN_DEPTH - 1; k > 0; k--) window_q[k] = window_q[k-1];
                window_q[0] = s_tdata;
                if (s_tlast) begin
                    want.found = seen_q;
                    want.addr  = seen_q ? base_q + ADDR_W'(offset_q) : '0;
                    range_results.push_back(want);
                    clear_scan();
                end
            end
        end
        pending_results = range_results.size();
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top of the scanner testbench: clock, reset, register setup, byte ranges and
// result back-pressure. Depends on mbps_pkg, masked_byte_pattern_scan, scan_checker.
module testbench;
    import mbps_pkg::*;

    // spare register indexes beyond the list; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 72;
    localparam int HOLD_PHASE      = 2;
    localparam int HOLD_CYCLES     = 200;
    // result hold stage plus output register, with some margin
    localparam int PIPE_SETTLE     = 4;
    localparam int MAX_RANGE       = 48;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = 8'h00;   // [7:0] data_byte
    logic                  s_tlast   = 1'b0;    // last_byte
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [ADDR_W-1:0]     m_tdata;             // [63:0] match_address
    logic                  m_tuser;             // [0] found

    int fail_count;
    int pending_results;

    // stimulus-side view of the current setup, used to plant the pattern
    logic [8*PAT_BYTES-1:0] pattern_now = '0;
    logic [PAT_BYTES-1:0]   mask_now    = MASK_RESET;
    int                     span        = 1;

    // idling controls shared between the sender and the receiver
    int gap_odds   = 0;
    bit hold_req   = 1'b0;
    bit quiet_tail = 1'b0;

    always #5 aclk = ~aclk;

    masked_byte_pattern_scan uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    scan_checker u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // Write one register; the enable drops on the following falling edge, so
    // back-to-back writes leave the enable low between them.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk) cfg_we <= 1'b0;
    endtask

    // Stop offering bytes, wait for every expected result, then let the
    // pipeline run empty so that nothing is in flight.
    task automatic settle();
        @(negedge aclk) s_tvalid <= 1'b0;
        wait (pending_results == 0);
        repeat (PIPE_SETTLE) @(negedge aclk);
    endtask

    // Program the whole register set while idle. Narrow registers get random
    // junk above their width, and the spare indexes get written too.
    task automatic load_setup(input logic [ADDR_W-1:0] base,
                              input logic [8*PAT_BYTES-1:0] pat,
                              input logic [PAT_BYTES-1:0] mask,
                              input logic [LEN_W-1:0] len,
                              input logic mode);
        logic [CFG_DATA_W-1:0] val;
        settle();
        write_reg(CFG_BASE_ADDRESS, base);
        write_reg(CFG_PATTERN_LOW, pat[63:0]);
        write_reg(CFG_PATTERN_HIGH, pat[127:64]);
        val = {$urandom, $urandom};
        val[PAT_BYTES-1:0] = mask;
        write_reg(CFG_COMPARE_MASK, val);
        val = {$urandom, $urandom};
        val[LEN_W-1:0] = len;
        write_reg(CFG_PATTERN_LENGTH, val);
        val = {$urandom, $urandom};
        val[0] = mode;
        write_reg(CFG_SEARCH_LAST, val);
        write_reg(IDX_SPARE_LO, {$urandom, $urandom});
        write_reg(IDX_SPARE_HI, {$urandom, $urandom});
        pattern_now = pat;
        mask_now    = mask;
        span        = (len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(len);
    endtask

    // Offer one item and hold it until the handshake completes. An optional
    // idle burst goes in front; valid is only driven once per falling edge.
    task automatic send_byte(input logic [7:0] value, input logic last);
        int gap;
        if (gap_odds != 0 && $urandom_range(1, 8) <= gap_odds) begin
            gap = $urandom_range(1, 14);
            @(negedge aclk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Build one range: random bytes mixed with pattern bytes for near misses,
    // and up to two planted copies of the pattern with random wildcard bytes.
    task automatic send_range(input int n);
        logic [7:0] bytes [MAX_RANGE];
        int         i;
        int         j;
        int         start;
        int         plants;
        for (i = 0; i < n; i++) begin
            if (span == 0 || $urandom_range(0, 1) != 0) begin
                bytes[i] = 8'($urandom);
            end else begin
                j = $urandom_range(0, span - 1);
                bytes[i] = pattern_now[8*j +: 8];
            end
        end
        plants = (span > 0 && n >= span) ? $urandom_range(0, 2) : 0;
        repeat (plants) begin
            start = $urandom_range(0, n - span);
            for (j = 0; j < span; j++)
                if (mask_now[j]) bytes[start + j] = pattern_now[8*j +: 8];
        end
        for (i = 0; i < n; i++) send_byte(bytes[i], i == n - 1);
    endtask

    // Receiver: ready and stalled in random stretches, one long hold-off on
    // request, and always ready in the quiet tail of the run.
    initial begin : receiver
        int   n;
        logic level;
        wait (aresetn);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                n     = HOLD_CYCLES;
                level = 1'b0;
            end else if (quiet_tail) begin
                n     = 1;
                level = 1'b1;
            end else if ($urandom_range(0, 2) == 0) begin
                n     = $urandom_range(1, 14);
                level = 1'b0;
            end else begin
                n     = $urandom_range(1, 30);
                level = 1'b1;
            end
            @(negedge aclk) m_tready <= level;
            repeat (n - 1) @(negedge aclk);
        end
    end

    initial begin : stimulus
        int                     p;
        int                     n;
        int                     items;
        logic [ADDR_W-1:0]      base;
        logic [8*PAT_BYTES-1:0] pat;
        logic [PAT_BYTES-1:0]   mask;
        logic [LEN_W-1:0]       len;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset setup: pattern byte 00, length 1, first mode. Expect a hit at
        // offset 1 on a range that ends in the extreme byte values.
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);

        // Zero pattern length: nothing can match.
        load_setup('0, '0, 16'hFFFF, 5'd0, 1'b0);
        send_byte(8'h00, 1'b1);

        // Range shorter than the pattern: the prefix matches, still not found.
        load_setup(64'h0000_0000_0000_1000, 128'h0055AA, 16'hFFFF, 5'd3, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);

        // Length above the maximum clamps to 16; all wildcards at the top base.
        load_setup('1, {$urandom, $urandom, $urandom, $urandom}, 16'h0000, 5'd31,
                   1'b0);
        for (n = 0; n < MAX_PATTERN_DEF; n++)
            send_byte(8'($urandom), n == MAX_PATTERN_DEF - 1);

        // Mode change in the middle of a range: the early hits keep the first
        // one, the later ones follow last mode.
        load_setup(64'hFFFF_FFFF_FFFF_FFF0, 128'h5A, 16'h0001, 5'd1, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h5A, 1'b0);
        settle();
        write_reg(CFG_SEARCH_LAST, 64'h1);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h00, 1'b1);

        // Random phases, each with its own setup; the first two pin extremes.
        for (p = 0; p < NUM_PHASES; p++) begin
            base = {$urandom, $urandom};
            pat  = {$urandom, $urandom, $urandom, $urandom};
            case ($urandom_range(0, 3))
                0:       mask = 16'hFFFF;
                1:       mask = 16'h0000;
                2:       mask = 16'h0001 << $urandom_range(0, 15);
                default: mask = 16'($urandom);
            endcase
            if ($urandom_range(0, 9) == 0) len = 5'($urandom_range(0, 31));
            else len = 5'($urandom_range(1, 16));
            if ($urandom_range(0, 3) == 0) base = $urandom_range(0, 1) ? '1 : '0;
            if (p == 0) begin
                base = '1;
                pat  = '1;
                mask = 16'hFFFF;
                len  = 5'd16;
            end else if (p == 1) begin
                base = '0;
                pat  = '0;
                mask = 16'h0000;
                len  = 5'd1;
            end
            load_setup(base, pat, mask, len, 1'($urandom_range(0, 1)));

            // Hold results back for a long stretch while short ranges keep
            // coming, so that the result stages fill and the input stalls.
            if (p == HOLD_PHASE) hold_req = 1'b1;
            if (p == NUM_PHASES - 1) quiet_tail = 1'b1;

            items = 0;
            while (items < ITEMS_PER_PHASE) begin
                gap_odds = quiet_tail ? 0 : $urandom_range(0, 3);
                if (p == HOLD_PHASE) n = $urandom_range(1, 3);
                else if ($urandom_range(0, 7) == 0) n = $urandom_range(1, MAX_RANGE);
                else n = $urandom_range(1, span + 6);
                send_range(n);
                items += n;
            end
        end

        // Drain: every expected result in, then a few more cycles for strays.
        settle();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin : watchdog
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

### masked_byte_pattern_scan.f
rtl/mbps_pkg.sv
rtl/mbps_cell.sv
rtl/masked_byte_pattern_scan.sv
tb/sv/scan_checker.sv
tb/sv/testbench.sv
